// ===== design/phase_current_sense_frontend_unit_defines.svh =====
// Assertion macros shared by the current sense front end modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef PHASE_CURRENT_SENSE_FRONTEND_UNIT_DEFINES_SVH
`define PHASE_CURRENT_SENSE_FRONTEND_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCSF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pcsf_pkg.sv =====
// Shared widths, codes and the lane control type of the current sense front end.
// No dependencies; every module of the block and the testbench import this package.
package pcsf_pkg;

	localparam int SAMPLE_W = 12;
	localparam int OFS_W = 12;
	localparam int SUM_W = 18;
	localparam int ZOFS_W = 14;
	localparam int PHASE_W = 14;
	localparam int PHASE2_W = 15;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 48;
	localparam int CAL_SAMPLES_DEF = 16;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;

	localparam logic MODE_CURRENT = 1'b0;
	localparam logic MODE_CAL = 1'b1;

	// Control that the top level hands to both channel lanes with each transfer.
	typedef struct packed {
		logic en;
		logic cal;
		logic restart;
		logic finish;
	} lane_ctrl_t;

endpackage

// ===== design/pcsf_lane.sv =====
// One shunt channel: offset add, clamp, zero-current subtraction and calibration sums.
// Depends on pcsf_pkg.
module pcsf_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcsf_pkg::lane_ctrl_t          ctrl,
	input  logic [pcsf_pkg::SAMPLE_W-1:0] sample,
	input  logic [pcsf_pkg::OFS_W-1:0]    conv_offset,
	output logic [pcsf_pkg::PHASE_W-1:0]  phase_s1
);
	import pcsf_pkg::*;

	localparam int ADJ_W = SAMPLE_W + 2;

	logic [ADJ_W-1:0]    adj;
	logic [SAMPLE_W-1:0] clamped;
	logic [PHASE_W-1:0]  phase;
	logic [SUM_W-1:0]    sum_base;
	logic [SUM_W-1:0]    sum_next;
	logic [SUM_W-1:0]    sum_q;
	logic [ZOFS_W-1:0]   zofs_q;

	// Sample plus signed converter offset, wide enough for the whole range.
	assign adj = {2'b00, sample} + {{(ADJ_W-OFS_W){conv_offset[OFS_W-1]}}, conv_offset};

	always_comb begin
		priority if (adj[ADJ_W-1]) begin
			clamped = '0;
		end else if (adj[ADJ_W-2]) begin
			clamped = SAMPLE_MAX;
		end else begin
			clamped = adj[SAMPLE_W-1:0];
		end
	end

	assign phase = {{(PHASE_W-SAMPLE_W){1'b0}}, clamped} - zofs_q;

	assign sum_base = ctrl.restart ? '0 : sum_q;
	assign sum_next = sum_base + {{(SUM_W-ADJ_W){adj[ADJ_W-1]}}, adj};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			zofs_q <= '0;
		end else if (ctrl.en && ctrl.cal) begin
			sum_q <= sum_next;
			// The offset is the sum shifted right by four, i.e. its upper bits.
			if (ctrl.finish) begin
				zofs_q <= sum_next[SUM_W-1 -: ZOFS_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			phase_s1 <= ctrl.cal ? '0 : phase;
		end
	end

endmodule

// ===== design/pcsf_merge.sv =====
// Merging stage: derives phase two from the lane results and holds the output register.
// Depends on pcsf_pkg and the assertion macro header.
`include "phase_current_sense_frontend_unit_defines.svh"
module pcsf_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s1_valid,
	input  logic [pcsf_pkg::PHASE_W-1:0]    p1_s1,
	input  logic [pcsf_pkg::PHASE_W-1:0]    p3_s1,
	input  logic                            done_s1,
	output logic                            adv,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, lowest bit up: phase_one[13:0], phase_two[28:14], phase_three[42:29], zeros
	output logic [pcsf_pkg::OUT_DATA_W-1:0] m_tdata,
	// m_tlast: calibration_done
	output logic                            m_tlast
);
	import pcsf_pkg::*;

	logic                out_valid_q;
	logic [PHASE_W-1:0]  out_p1_q;
	logic [PHASE2_W-1:0] out_p2_q;
	logic [PHASE_W-1:0]  out_p3_q;
	logic                out_done_q;
	logic [PHASE2_W-1:0] p2;
	logic [PHASE2_W-1:0] chk_sum;

	assign adv = !out_valid_q || m_tready;

	assign p2 = '0 - ({p1_s1[PHASE_W-1], p1_s1} + {p3_s1[PHASE_W-1], p3_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid) begin
			out_p1_q <= p1_s1;
			out_p2_q <= p2;
			out_p3_q <= p3_s1;
			out_done_q <= done_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(OUT_DATA_W-2*PHASE_W-PHASE2_W){1'b0}}, out_p3_q, out_p2_q, out_p1_q};
	assign m_tlast = out_done_q;

	assign chk_sum = out_p2_q + {out_p1_q[PHASE_W-1], out_p1_q} + {out_p3_q[PHASE_W-1], out_p3_q};

	`PCSF_ASSERT_SAME(a_done_zero, out_valid_q && out_done_q, out_p1_q == '0 && out_p3_q == '0 && out_p2_q == '0, "calibration result carries nonzero currents")
	`PCSF_ASSERT_SAME(a_p2_balance, out_valid_q, chk_sum == '0, "phase currents do not sum to zero")
	`PCSF_ASSERT_NEXT(a_load, adv && s1_valid, out_valid_q, "result lost between stage one and output")

endmodule

// ===== design/phase_current_sense_frontend_unit.sv =====
// Top level of the phase current sense front end: handshakes, calibration counter,
// converter offset register, two channel lanes and the merging stage. Uses pcsf_pkg.
//
//  channel  signals                               direction  payload
//  s        s_tvalid s_tready s_tdata s_tuser     in         sample pair and mode
//  m        m_tvalid m_tready m_tdata m_tlast     out        phase currents and done flag
//  cfg      cfg_valid cfg_ready cfg_data          in         converter offset
//
// One item per cycle sustained while the output is not stalled; each result passes through
// the lane register and then the output register of the merging stage.
// Reset clears the counter, sums, zero offsets and converter offset; no clearing pass.
// A stall at the output holds both stages, and s_tready falls only when both are full.
// cfg_ready is always high.
`include "phase_current_sense_frontend_unit_defines.svh"
module phase_current_sense_frontend_unit #(
	parameter int CAL_SAMPLES = pcsf_pkg::CAL_SAMPLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, lowest bit up: sample_a[11:0], sample_b[23:12]
	input  logic [pcsf_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser: mode
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, lowest bit up: phase_one[13:0], phase_two[28:14], phase_three[42:29], zeros
	output logic [pcsf_pkg::OUT_DATA_W-1:0] m_tdata,
	// m_tlast: calibration_done
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pcsf_pkg::OFS_W-1:0]      cfg_data
);
	import pcsf_pkg::*;

	localparam int CNT_W = $clog2(CAL_SAMPLES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

	logic               s_accept;
	logic               cal_item;
	logic               cnt_last;
	logic [CNT_W-1:0]   cal_cnt_q;
	logic [OFS_W-1:0]   conv_offset_q;
	logic               s1_valid_q;
	logic               done_s1;
	logic               adv;
	lane_ctrl_t         ctrl;
	logic [PHASE_W-1:0] p1_s1;
	logic [PHASE_W-1:0] p3_s1;

	assign cfg_ready = 1'b1;
	assign s_tready = !s1_valid_q || adv;
	assign s_accept = s_tvalid && s_tready;
	assign cal_item = (s_tuser[0] == MODE_CAL);
	assign cnt_last = (cal_cnt_q == CNT_LAST);

	assign ctrl.en = s_accept;
	assign ctrl.cal = cal_item;
	assign ctrl.restart = (cal_cnt_q == '0);
	assign ctrl.finish = cnt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			conv_offset_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cnt_q <= '0;
		end else if (s_accept && cal_item) begin
			cal_cnt_q <= cnt_last ? '0 : cal_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			done_s1 <= cal_item && cnt_last;
		end
	end

	pcsf_lane u_lane_a (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.sample      (s_tdata[SAMPLE_W-1:0]),
		.conv_offset (conv_offset_q),
		.phase_s1    (p1_s1)
	);

	pcsf_lane u_lane_b (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.sample      (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.conv_offset (conv_offset_q),
		.phase_s1    (p3_s1)
	);

	pcsf_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid_q),
		.p1_s1    (p1_s1),
		.p3_s1    (p3_s1),
		.done_s1  (done_s1),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`PCSF_ASSERT_NEXT(a_cnt_wrap, s_accept && cal_item && cnt_last, cal_cnt_q == '0, "calibration counter did not restart after a run")
	`PCSF_ASSERT_NEXT(a_cnt_hold, s_accept && !cal_item, $stable(cal_cnt_q), "current sample moved the calibration counter")
	`PCSF_ASSERT_SAME(a_done_cnt, s1_valid_q && done_s1, cal_cnt_q == '0, "completed run left the counter running")

endmodule

// ===== dv/phase_current_sense_frontend_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for phase_current_sense_frontend_unit: random sample pairs and
// calibration runs are streamed in, and each result is checked against a local predictor.
// Depends on pcsf_pkg and the top-level RTL only.
module phase_current_sense_frontend_unit_tb;

	import pcsf_pkg::*;

	localparam int CAL_N = CAL_SAMPLES_DEF;
	localparam int LATENCY = 2;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic                mode;
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
	} sample_pair_t;

	typedef struct packed {
		logic signed [PHASE_W-1:0]  i1;
		logic signed [PHASE2_W-1:0] i2;
		logic signed [PHASE_W-1:0]  i3;
		logic                       done;
	} phase_currents_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [OFS_W-1:0]      cfg_data = '0;

	// Predictor state, mirroring the block's registers.
	int                       cal_count;
	logic signed [SUM_W-1:0]  sum_a, sum_b;
	logic signed [ZOFS_W-1:0] zofs_a, zofs_b;
	logic signed [OFS_W-1:0]  conv_ofs;

	sample_pair_t    pending_pairs[$];
	phase_currents_t expected_currents[$];
	sample_pair_t    pair_on_bus;

	int errors, pairs_sent, currents_seen, runs_done, offsets_written, idle_cycles;
	int send_gap, send_steady, recv_hold, recv_steady;
	logic send_valid_nxt;

	phase_current_sense_frontend_unit #(
		.CAL_SAMPLES(CAL_N)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Works out the result of one sample pair and advances the calibration state.
	function automatic phase_currents_t sense_pair(input sample_pair_t p);
		phase_currents_t r;
		int va, vb, ca, cb;
		r = '0;
		va = int'(p.a) + int'(conv_ofs);
		vb = int'(p.b) + int'(conv_ofs);
		if (p.mode == MODE_CAL) begin
			if (cal_count == 0) begin
				sum_a = '0;
				sum_b = '0;
			end
			sum_a = sum_a + va;
			sum_b = sum_b + vb;
			cal_count++;
			if (cal_count >= CAL_N) begin
				zofs_a = sum_a[SUM_W-1:4];
				zofs_b = sum_b[SUM_W-1:4];
				cal_count = 0;
				r.done = 1'b1;
			end
		end else begin
			ca = (va < 0) ? 0 : ((va > int'(SAMPLE_MAX)) ? int'(SAMPLE_MAX) : va);
			cb = (vb < 0) ? 0 : ((vb > int'(SAMPLE_MAX)) ? int'(SAMPLE_MAX) : vb);
			r.i1 = ca - int'(zofs_a);
			r.i3 = cb - int'(zofs_b);
			r.i2 = -(int'(r.i1) + int'(r.i3));
		end
		return r;
	endfunction

	// Mostly no gap, some short ones, a few long ones, and now and then a long steady stretch.
	function automatic int idle_gap(inout int steady, input int zero_pct);
		int r;
		if (steady > 0) begin
			steady--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			steady = $urandom_range(30, 120);
			return 0;
		end
		if (r < zero_pct)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return SAMPLE_MAX;
		return SAMPLE_W'($urandom_range(0, int'(SAMPLE_MAX)));
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		errors++;
		$display("ERROR at %0t: %s is %0d, expected %0d", $time, field, got, want);
	endtask

	task automatic push_pair(input logic mode, input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b);
		sample_pair_t p;
		p.mode = mode;
		p.a = a;
		p.b = b;
		pending_pairs.push_back(p);
	endtask

	task automatic push_cal_run(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
		repeat (CAL_N) push_pair(MODE_CAL, a, b);
	endtask

	// Returns once every queued pair has gone in and every result has come out.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_pairs.size() != 0 || s_tvalid || expected_currents.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_converter_offset(input logic signed [OFS_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		conv_ofs = v;
		offsets_written++;
		cfg_valid <= 1'b0;
	endtask

	// Mostly complete calibration runs, some with current pairs mixed in, plus broken runs
	// and bursts of current pairs.
	task automatic fill_random_phase(input int target);
		int n, r, k;
		n = 0;
		while (n < target) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				for (k = 0; k < CAL_N; k++) begin
					if ($urandom_range(0, 4) == 0) begin
						push_pair(MODE_CURRENT, rand_sample(), rand_sample());
						n++;
					end
					push_pair(MODE_CAL, rand_sample(), rand_sample());
					n++;
				end
			end else if (r < 60) begin
				k = $urandom_range(1, CAL_N - 1);
				n += k;
				repeat (k) push_pair(MODE_CAL, rand_sample(), rand_sample());
			end else begin
				k = $urandom_range(5, 20);
				n += k;
				repeat (k) push_pair(MODE_CURRENT, rand_sample(), rand_sample());
			end
		end
	endtask

	// Sender: presents queued pairs and predicts each one as its transfer completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			cal_count = 0;
			sum_a = '0;
			sum_b = '0;
			zofs_a = '0;
			zofs_b = '0;
			conv_ofs = '0;
		end else begin
			send_valid_nxt = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected_currents.push_back(sense_pair(pair_on_bus));
				pairs_sent++;
				send_valid_nxt = 1'b0;
				send_gap = idle_gap(send_steady, 60);
			end else if (!s_tvalid && send_gap > 0) begin
				send_gap--;
			end
			if (!send_valid_nxt && send_gap == 0 && pending_pairs.size() != 0) begin
				pair_on_bus = pending_pairs.pop_front();
				s_tdata <= {pair_on_bus.b, pair_on_bus.a};
				s_tuser <= pair_on_bus.mode;
				send_valid_nxt = 1'b1;
			end
			s_tvalid <= send_valid_nxt;
		end
	end

	// Receiver: random back-pressure and a field-by-field check of every result transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				phase_currents_t want;
				phase_currents_t got;
				got.i1 = m_tdata[PHASE_W-1:0];
				got.i2 = m_tdata[PHASE_W +: PHASE2_W];
				got.i3 = m_tdata[PHASE_W+PHASE2_W +: PHASE_W];
				got.done = m_tlast;
				currents_seen++;
				if (expected_currents.size() == 0) begin
					report_mismatch("result transfer with nothing predicted, phase_one",
						int'(got.i1), 0);
				end else begin
					want = expected_currents.pop_front();
					if (got.done)
						runs_done++;
					if (got.i1 !== want.i1)
						report_mismatch("phase_one", int'(got.i1), int'(want.i1));
					if (got.i2 !== want.i2)
						report_mismatch("phase_two", int'(got.i2), int'(want.i2));
					if (got.i3 !== want.i3)
						report_mismatch("phase_three", int'(got.i3), int'(want.i3));
					if (got.done !== want.done)
						report_mismatch("calibration_done", int'(got.done), int'(want.done));
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_tready <= 1'b0;
			end else begin
				recv_hold = idle_gap(recv_steady, 75);
				m_tready <= (recv_hold == 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic signed [OFS_W-1:0] ofs;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes with no offsets, a run of full-scale and zero samples
		// with a current pair inside it, then currents against the new offsets.
		push_pair(MODE_CURRENT, '0, '0);
		push_pair(MODE_CURRENT, SAMPLE_MAX, SAMPLE_MAX);
		push_pair(MODE_CURRENT, '0, SAMPLE_MAX);
		push_pair(MODE_CURRENT, SAMPLE_MAX, '0);
		repeat (CAL_N / 2) push_pair(MODE_CAL, SAMPLE_MAX, '0);
		push_pair(MODE_CURRENT, 12'h800, 12'h7FF);
		repeat (CAL_N - CAL_N / 2) push_pair(MODE_CAL, SAMPLE_MAX, '0);
		push_pair(MODE_CURRENT, '0, '0);
		push_pair(MODE_CURRENT, SAMPLE_MAX, SAMPLE_MAX);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			if (ph == 0 || ph == 2)
				ofs = 12'sh7FF;
			else if (ph == 1)
				ofs = 12'sh800;
			else if (ph == 3)
				ofs = '0;
			else
				ofs = OFS_W'($urandom);
			write_converter_offset(ofs);
			// Largest offsets first, so that zero input gives the most negative currents.
			if (ph == 0) begin
				push_cal_run(SAMPLE_MAX, SAMPLE_MAX);
				push_pair(MODE_CURRENT, '0, '0);
			end
			// Offsets calibrated at the lowest setting meet the highest one here.
			if (ph == 2)
				push_pair(MODE_CURRENT, SAMPLE_MAX, SAMPLE_MAX);
			fill_random_phase(PHASE_ITEMS);
			if (ph == 1)
				push_cal_run('0, '0);
		end
		wait_drained();

		$display("Sent %0d sample pairs over %0d converter offset settings;",
			pairs_sent, offsets_written + 1);
		$display("checked %0d results, %0d of them closing a calibration run.",
			currents_seen, runs_done);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/pcsf_pkg.sv
design/pcsf_lane.sv
design/pcsf_merge.sv
design/phase_current_sense_frontend_unit.sv
dv/phase_current_sense_frontend_unit_tb.sv
